// ===== hw/rtl/prpi_pkg.sv =====
package prpi_pkg;

  // Sizes
  localparam int MAX_NODES = 256;
  localparam int NODE_W    = 8;     // node index
  localparam int CNT_W     = 9;     // node count, 1..256
  localparam int RANK_W    = 32;    // Q1.31 rank
  localparam int SUM_W     = 40;    // sum of 256 rank changes
  localparam int DEG_W     = 9;     // out-degree, 0..256

  localparam logic [16:0]       DAMP_ONE = 17'h1_0000;
  localparam logic [RANK_W-1:0] RANK_ONE = 32'h8000_0000;

  // Input item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // Result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_RANK   = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_ITER_LIMIT = 2'd1;
  localparam logic [1:0] REG_DAMPING    = 2'd2;
  localparam logic [1:0] REG_EPSILON    = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_RD_RD,
    ST_RD_CAP,
    ST_PUT,
    ST_INIT_DIV,
    ST_TELE_DIV,
    ST_SWEEP,
    ST_ITER,
    ST_J_RD,
    ST_J_DAT,
    ST_J_DIV,
    ST_DRAIN,
    ST_DRAIN_END,
    ST_DIFF_DIV
  } state_t;

  // Accumulator chain control
  typedef struct packed {
    logic clear;
    logic shift;
    logic add;
  } chain_ctl_t;

endpackage

// ===== hw/rtl/prpi_ram.sv =====
module prpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/prpi_div.sv =====
module prpi_div
  import prpi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  // Restoring divider, one quotient bit per cycle
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic [5:0]       cnt;
  logic             busy;
  logic [CNT_W:0]   trial;
  logic             ge;

  assign trial = {rem, quotient[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], ge};
      rem      <= ge ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/prpi_cell.sv =====
module prpi_cell
  import prpi_pkg::*;
(
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic [RANK_W-1:0] add_val,
  input  logic              sel,
  input  logic [RANK_W-1:0] acc_in,
  output logic [RANK_W-1:0] acc
);

  logic [RANK_W:0] sum;

  assign sum = {1'b0, acc} + {1'b0, add_val};

  // Saturating accumulator; shift hands the value to the left neighbor
  always_ff @(posedge clk) begin
    priority if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.shift) begin
      acc <= acc_in;
    end else if (ctl.add && sel) begin
      acc <= sum[RANK_W] ? '1 : sum[RANK_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/prpi_chain.sv =====
module prpi_chain
  import prpi_pkg::*;
(
  input  logic                 clk,
  input  chain_ctl_t           ctl,
  input  logic [RANK_W-1:0]    add_val,
  input  logic [MAX_NODES-1:0] mask,
  output logic [RANK_W-1:0]    head
);

  logic [RANK_W-1:0] acc [MAX_NODES];
  logic [RANK_W-1:0] nbr [MAX_NODES];

  // Cell i holds the in-sum of node i; draining shifts toward cell 0
  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    if (i == MAX_NODES - 1) begin : g_last
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i] = acc[i+1];
    end

    prpi_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .add_val (add_val),
      .sel     (mask[i]),
      .acc_in  (nbr[i]),
      .acc     (acc[i])
    );
  end

  assign head = acc[0];

endmodule

// ===== hw/rtl/pagerank_power_iteration.sv =====
// PageRank power-iteration engine.
// Input channel (in_valid/in_stall) takes one item per beat: load edge, run,
// read rank or clear graph. Output channel (out_valid/out_stall) carries one
// result beat for each run and each read; loads and clears give none.
// Registers must be written over the APB port only while the block is idle;
// the block itself does not enforce it. Edge load reads the source row and
// writes it back; a clear acts when it is taken. Rank read passes through
// ST_RD_RD, ST_RD_CAP and ST_PUT, and the input is free again in the same
// cycle as the result beat. Run: setup of two divides and a rank write sweep
// over all 256 entries, then per iteration each source node costs a row read
// and, if its out-degree is not zero, one serial divide of its rank by its
// out-degree, broadcast into a chain of 256 accumulator cells; then the
// chain drains one node per cycle through the damping multiply, and a final
// divide forms the mean change. All divides share the one divider.
// Reset empties the graph, makes rank reads give zero until the first run
// and loads the default registers; no clearing pass is needed. While the
// output beat is stalled the finished result holds in the output register
// and the block takes further items that give no result.
module pagerank_power_iteration
  import prpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  from_node,
  input  logic [7:0]  to_node,
  input  logic [7:0]  query_node,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [31:0] rank_q31,
  output logic [7:0]  node,
  output logic [7:0]  iterations,
  output logic        converged,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [8:0]  node_count;
  logic [7:0]  iteration_limit;
  logic [16:0] damping_q16;
  logic [31:0] epsilon_q31;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= 9'd256;
      iteration_limit <= 8'd50;
      damping_q16     <= DAMP_ONE;
      epsilon_q31     <= 32'd2147;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_NODE_COUNT: node_count      <= pwdata[8:0];
        REG_ITER_LIMIT: iteration_limit <= pwdata[7:0];
        REG_DAMPING:    damping_q16     <= pwdata[16:0];
        REG_EPSILON:    epsilon_q31     <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NODE_COUNT: prdata = {23'b0, node_count};
      REG_ITER_LIMIT: prdata = {24'b0, iteration_limit};
      REG_DAMPING:    prdata = {15'b0, damping_q16};
      REG_EPSILON:    prdata = epsilon_q31;
    endcase
  end

  // Effective settings
  logic [CNT_W-1:0] n_eff;
  logic [16:0]      d_eff;
  logic [7:0]       lim_eff;
  logic [16:0]      d_comp;

  always_comb begin
    if (node_count == '0) begin
      n_eff = 9'd1;
    end else if (node_count > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
    d_eff   = (damping_q16 > DAMP_ONE) ? DAMP_ONE : damping_q16;
    lim_eff = (iteration_limit == '0) ? 8'd1 : iteration_limit;
    d_comp  = DAMP_ONE - d_eff;
  end

  // Control and datapath registers
  state_t               state, state_next;
  logic [NODE_W-1:0]    f_r, t_r, q_r;
  logic [CNT_W-1:0]     j, k, idx;
  logic [7:0]           it;
  logic [RANK_W-1:0]    init_val, tele;
  logic [SUM_W-1:0]     diff;
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] row_r;
  logic                 ever_run;
  logic                 sa_valid;
  logic [NODE_W-1:0]    sa_idx;
  logic [32:0]          p1;
  logic [16:0]          p2;

  logic                 res_kind, res_conv;
  logic [RANK_W-1:0]    res_rank;
  logic [NODE_W-1:0]    res_node;
  logic [7:0]           res_iter;

  // Memories
  logic [MAX_NODES-1:0] adj_q, adj_wdata;
  logic [DEG_W-1:0]     deg_q, deg_wdata;
  logic [RANK_W-1:0]    cur_q, cur_wdata;
  logic [NODE_W-1:0]    adj_raddr, cur_raddr, cur_waddr;
  logic                 adj_we, cur_we;

  // Divider
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_a, div_q;
  logic [CNT_W-1:0] div_b;

  // Chain
  chain_ctl_t        chain_ctl;
  logic [RANK_W-1:0] head;

  // Misc combinational
  logic                 in_acc, out_free, last_j, row_ok, load_ok, conv, stop;
  logic [MAX_NODES-1:0] row_eff, t_hot;
  logic [DEG_W-1:0]     deg_eff;
  logic [33:0]          vsum;
  logic [RANK_W-1:0]    nxt, absd;
  logic [32:0]          m1, m2;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_j   = (j + 9'd1) == n_eff;
  assign load_ok  = ({1'b0, from_node} < n_eff) && ({1'b0, to_node} < n_eff);
  assign conv     = div_q <= {8'b0, epsilon_q31};
  assign stop     = conv || (it == lim_eff);

  // Row data is valid only for rows written since the last clear
  assign row_ok  = row_valid[(state == ST_LD_WR) ? f_r : j[NODE_W-1:0]];
  assign row_eff = row_ok ? adj_q : '0;
  assign deg_eff = row_ok ? deg_q : '0;
  assign t_hot   = MAX_NODES'(1) << t_r;

  assign adj_raddr = (state == ST_LD_RD) ? f_r : j[NODE_W-1:0];
  assign adj_we    = (state == ST_LD_WR) && !row_eff[t_r];
  assign adj_wdata = row_eff | t_hot;
  assign deg_wdata = deg_eff + 9'd1;

  always_comb begin
    unique case (state)
      ST_RD_RD: cur_raddr = q_r;
      ST_DRAIN: cur_raddr = k[NODE_W-1:0];
      default:  cur_raddr = j[NODE_W-1:0];
    endcase
  end

  // Damping multiply of the chain head
  assign m1 = {17'b0, head[31:16]} * {16'b0, d_eff};
  assign m2 = {17'b0, head[15:0]} * {16'b0, d_eff};

  // New rank and change, one node behind the multiply
  assign vsum = {1'b0, p1} + {17'b0, p2} + {2'b0, tele};
  assign nxt  = (vsum[33:32] != 2'b0) ? '1 : vsum[31:0];
  assign absd = (cur_q > nxt) ? (cur_q - nxt) : (nxt - cur_q);

  assign cur_we    = (state == ST_SWEEP) || sa_valid;
  assign cur_waddr = sa_valid ? sa_idx : idx[NODE_W-1:0];
  assign cur_wdata = sa_valid ? nxt : ((idx < n_eff) ? init_val : '0);

  prpi_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (f_r),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_q)
  );

  prpi_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (f_r),
    .wdata (deg_wdata),
    .raddr (adj_raddr),
    .rdata (deg_q)
  );

  prpi_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (cur_raddr),
    .rdata (cur_q)
  );

  prpi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  prpi_chain u_chain (
    .clk     (clk),
    .ctl     (chain_ctl),
    .add_val (div_q[RANK_W-1:0]),
    .mask    (row_r),
    .head    (head)
  );

  // Next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = n_eff;
    chain_ctl  = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (mode)
            MODE_LOAD: begin
              if (load_ok) begin
                state_next = ST_LD_RD;
              end
            end
            MODE_RUN: begin
              div_start  = 1'b1;
              div_a      = {8'b0, RANK_ONE};
              state_next = ST_INIT_DIV;
            end
            MODE_READ:  state_next = ST_RD_RD;
            MODE_CLEAR: state_next = ST_IDLE;
          endcase
        end
      end
      ST_LD_RD:  state_next = ST_LD_WR;
      ST_LD_WR:  state_next = ST_IDLE;
      ST_RD_RD:  state_next = ST_RD_CAP;
      ST_RD_CAP: state_next = ST_PUT;
      ST_PUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_INIT_DIV: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_a      = {8'b0, d_comp, 15'b0};
          state_next = ST_TELE_DIV;
        end
      end
      ST_TELE_DIV: begin
        if (div_done) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (idx == CNT_W'(MAX_NODES - 1)) begin
          state_next = ST_ITER;
        end
      end
      ST_ITER: begin
        chain_ctl.clear = 1'b1;
        state_next      = ST_J_RD;
      end
      ST_J_RD: state_next = ST_J_DAT;
      ST_J_DAT: begin
        if (deg_eff != '0) begin
          div_start  = 1'b1;
          div_a      = {8'b0, cur_q};
          div_b      = deg_eff;
          state_next = ST_J_DIV;
        end else begin
          state_next = last_j ? ST_DRAIN : ST_J_RD;
        end
      end
      ST_J_DIV: begin
        if (div_done) begin
          chain_ctl.add = 1'b1;
          state_next    = last_j ? ST_DRAIN : ST_J_RD;
        end
      end
      ST_DRAIN: begin
        if (k == n_eff) begin
          state_next = ST_DRAIN_END;
        end else begin
          chain_ctl.shift = 1'b1;
        end
      end
      ST_DRAIN_END: begin
        div_start  = 1'b1;
        div_a      = diff;
        state_next = ST_DIFF_DIV;
      end
      ST_DIFF_DIV: begin
        if (div_done) begin
          state_next = stop ? ST_PUT : ST_ITER;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      ever_run  <= 1'b0;
      sa_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      sa_valid <= (state == ST_DRAIN) && (k != n_eff);
      if (in_acc && (mode == MODE_CLEAR)) begin
        row_valid <= '0;
      end else if (state == ST_LD_WR) begin
        row_valid[f_r] <= 1'b1;
      end
      if (state == ST_SWEEP) begin
        ever_run <= 1'b1;
      end
      if ((state == ST_PUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          f_r <= from_node;
          t_r <= to_node;
          q_r <= query_node;
        end
      end
      ST_RD_CAP: begin
        res_kind <= KIND_RANK;
        res_rank <= ever_run ? cur_q : '0;
        res_node <= q_r;
        res_iter <= '0;
        res_conv <= 1'b0;
      end
      ST_INIT_DIV: begin
        if (div_done) begin
          init_val <= div_q[RANK_W-1:0];
        end
      end
      ST_TELE_DIV: begin
        if (div_done) begin
          tele <= div_q[RANK_W-1:0];
        end
        idx <= '0;
      end
      ST_SWEEP: begin
        idx <= idx + 9'd1;
        it  <= 8'd1;
      end
      ST_ITER: begin
        j <= '0;
        k <= '0;
      end
      ST_J_DAT: begin
        row_r <= row_eff;
        if (deg_eff == '0) begin
          j <= j + 9'd1;
        end
      end
      ST_J_DIV: begin
        if (div_done) begin
          j <= j + 9'd1;
        end
      end
      ST_DRAIN: begin
        if (k != n_eff) begin
          k      <= k + 9'd1;
          sa_idx <= k[NODE_W-1:0];
          p1     <= m1;
          p2     <= m2[32:16];
        end
      end
      ST_DIFF_DIV: begin
        if (div_done) begin
          res_kind <= KIND_REPORT;
          res_rank <= '0;
          res_node <= '0;
          res_iter <= it;
          res_conv <= conv;
          if (!stop) begin
            it <= it + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase

    // Mean-change sum, cleared at each iteration start
    if (state == ST_ITER) begin
      diff <= '0;
    end else if (sa_valid) begin
      diff <= diff + {8'b0, absd};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state == ST_PUT) && out_free) begin
      kind       <= res_kind;
      rank_q31   <= res_rank;
      node       <= res_node;
      iterations <= res_iter;
      converged  <= res_conv;
    end
  end

endmodule
